### design/nearest_joint_vector_select_macros.svh
// assertion macros shared by the nearest joint vector select rtl
// no dependencies; included by the modules that carry checks
`ifndef NEAREST_JOINT_VECTOR_SELECT_MACROS_SVH
`define NEAREST_JOINT_VECTOR_SELECT_MACROS_SVH
`ifndef SYNTHESIS
`define NJVS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: check failed");
`define NJVS_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define NJVS_ASSERT(lbl, clk, rstn, prop)
`define NJVS_NEVER(lbl, clk, rstn, expr)
`endif
`endif

### design/njvs_pkg.sv
// types and constants of the nearest joint vector select block
// no dependencies; used by every other file of the block but the macros header
`timescale 1ns / 1ps
`default_nettype none
package njvs_pkg;

  localparam int NUM_JOINT_FIELDS = 6;
  localparam int JOINTS = 6;
  localparam int MAX_CANDIDATES = 128;
  localparam int QUEUE_DEPTH = 2;

  localparam int ANGLE_W = 16;
  localparam int LIMIT_W = 19;
  localparam int SUM_W = 20;
  localparam int INDEX_W = 7;
  localparam int CNT_W = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int CFG_IDX_W = 3;

  localparam logic [LIMIT_W-1:0] DEFAULT_LIMIT = LIMIT_W'(409600);

  typedef logic [ANGLE_W-1:0] angle_t;
  typedef angle_t [NUM_JOINT_FIELDS-1:0] angle_vec_t;
  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [LIMIT_W-1:0] limit_t;
  typedef logic [INDEX_W-1:0] index_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REF_JOINT_0    = 3'd0,
    CFG_REF_JOINT_1    = 3'd1,
    CFG_REF_JOINT_2    = 3'd2,
    CFG_REF_JOINT_3    = 3'd3,
    CFG_REF_JOINT_4    = 3'd4,
    CFG_REF_JOINT_5    = 3'd5,
    CFG_DISTANCE_LIMIT = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] cand_joint_0;
    logic signed [ANGLE_W-1:0] cand_joint_1;
    logic signed [ANGLE_W-1:0] cand_joint_2;
    logic signed [ANGLE_W-1:0] cand_joint_3;
    logic signed [ANGLE_W-1:0] cand_joint_4;
    logic signed [ANGLE_W-1:0] cand_joint_5;
    logic                      last;
  } cand_t;

  typedef struct packed {
    logic                      found;
    logic [INDEX_W-1:0]        best_index;
    logic signed [ANGLE_W-1:0] best_joint_0;
    logic signed [ANGLE_W-1:0] best_joint_1;
    logic signed [ANGLE_W-1:0] best_joint_2;
    logic signed [ANGLE_W-1:0] best_joint_3;
    logic signed [ANGLE_W-1:0] best_joint_4;
    logic signed [ANGLE_W-1:0] best_joint_5;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [LIMIT_W-1:0]   wdata;
  } cfg_t;

  // one classified candidate waiting for the back end
  typedef struct packed {
    sum_t       sum;
    angle_vec_t angles;
    logic       last;
  } entry_t;

endpackage
`default_nettype wire

### design/njvs_if.sv
// valid/ready channel interfaces of the nearest joint vector select block
// depends on njvs_pkg for the payload types
`timescale 1ns / 1ps
`default_nettype none
interface njvs_cand_if;
  logic           valid;
  logic           ready;
  njvs_pkg::cand_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface njvs_result_if;
  logic             valid;
  logic             ready;
  njvs_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface njvs_cfg_if;
  logic          valid;
  logic          ready;
  njvs_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/njvs_front.sv
// front end: takes candidates, forms the l1 distance to the reference
// depends on njvs_pkg and njvs_cand_if
`timescale 1ns / 1ps
`default_nettype none
module njvs_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  njvs_cand_if.sink                 cand_i,
  input  wire njvs_pkg::angle_vec_t ref_joint_i,
  input  wire logic                 q_ready_i,
  output logic                      push_o,
  output njvs_pkg::entry_t          entry_o
);

  njvs_pkg::angle_vec_t cand_ang;
  njvs_pkg::angle_vec_t absd;
  njvs_pkg::angle_vec_t keep_ang;
  logic signed [njvs_pkg::ANGLE_W:0] diff [njvs_pkg::NUM_JOINT_FIELDS];

  logic                 s1_valid_q;
  njvs_pkg::angle_vec_t s1_absd_q;
  njvs_pkg::angle_vec_t s1_ang_q;
  logic                 s1_last_q;
  logic                 load;
  njvs_pkg::sum_t       sum;

  assign cand_ang[0] = cand_i.data.cand_joint_0;
  assign cand_ang[1] = cand_i.data.cand_joint_1;
  assign cand_ang[2] = cand_i.data.cand_joint_2;
  assign cand_ang[3] = cand_i.data.cand_joint_3;
  assign cand_ang[4] = cand_i.data.cand_joint_4;
  assign cand_ang[5] = cand_i.data.cand_joint_5;

  // per joint |cand - ref|, inactive joints count zero and are not kept
  always_comb begin
    for (int j = 0; j < njvs_pkg::NUM_JOINT_FIELDS; j++) begin
      diff[j] = {cand_ang[j][njvs_pkg::ANGLE_W-1], cand_ang[j]}
              - {ref_joint_i[j][njvs_pkg::ANGLE_W-1], ref_joint_i[j]};
      if (j < njvs_pkg::JOINTS) begin
        absd[j]     = diff[j][njvs_pkg::ANGLE_W] ? njvs_pkg::ANGLE_W'(-diff[j])
                                                 : diff[j][njvs_pkg::ANGLE_W-1:0];
        keep_ang[j] = cand_ang[j];
      end else begin
        absd[j]     = '0;
        keep_ang[j] = '0;
      end
    end
  end

  assign cand_i.ready = !s1_valid_q || q_ready_i;
  assign load         = cand_i.valid && cand_i.ready;
  assign push_o       = s1_valid_q && q_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (cand_i.ready) begin
      s1_valid_q <= cand_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_absd_q <= absd;
      s1_ang_q  <= keep_ang;
      s1_last_q <= cand_i.data.last;
    end
  end

  // six term sum, at most 6 * 65535 so it fits well inside 20 bits
  always_comb begin
    sum = '0;
    for (int j = 0; j < njvs_pkg::NUM_JOINT_FIELDS; j++) begin
      sum = sum + njvs_pkg::SUM_W'(s1_absd_q[j]);
    end
  end

  assign entry_o.sum    = sum;
  assign entry_o.angles = s1_ang_q;
  assign entry_o.last   = s1_last_q;

endmodule
`default_nettype wire

### design/njvs_queue.sv
// short queue between the front end and the back end
// depends on njvs_pkg and the assertion macros
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_joint_vector_select_macros.svh"
module njvs_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire njvs_pkg::entry_t entry_i,
  output logic                  ready_o,
  output logic                  valid_o,
  input  wire logic             pop_i,
  output njvs_pkg::entry_t      entry_o
);

  localparam int PTR_W = (njvs_pkg::QUEUE_DEPTH > 1) ? $clog2(njvs_pkg::QUEUE_DEPTH) : 1;
  localparam int OCC_W = $clog2(njvs_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(njvs_pkg::QUEUE_DEPTH - 1);
  localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(njvs_pkg::QUEUE_DEPTH);

  njvs_pkg::entry_t slot_q [njvs_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [OCC_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign ready_o = (count_q != FULL_OCC);
  assign valid_o = (count_q != '0);
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign entry_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  `NJVS_NEVER(a_q_overfill, clk_i, rst_ni, count_q > FULL_OCC)
  `NJVS_ASSERT(a_q_grow, clk_i, rst_ni, (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
  `NJVS_ASSERT(a_q_ptr_gap, clk_i, rst_ni, (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))

endmodule
`default_nettype wire

### design/njvs_back.sv
// back end: keeps the nearest candidate of a set and emits the result
// depends on njvs_pkg, njvs_result_if and the assertion macros
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_joint_vector_select_macros.svh"
module njvs_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire njvs_pkg::entry_t entry_i,
  output logic                  pop_o,
  input  wire njvs_pkg::limit_t limit_i,
  njvs_result_if.source         res_o
);

  logic                 res_valid_q;
  njvs_pkg::result_t    res_data_q;
  logic                 have_best_q;
  njvs_pkg::cnt_t       count_q;
  njvs_pkg::sum_t       best_dist_q;
  njvs_pkg::cnt_t       best_pos_q;
  njvs_pkg::angle_vec_t best_ang_q;

  njvs_pkg::sum_t       bound;
  logic                 take;
  logic                 out_free;
  logic                 emit;
  logic                 found;
  njvs_pkg::cnt_t       win_pos;
  njvs_pkg::angle_vec_t win_ang;
  njvs_pkg::result_t    res_d;

  // until something is kept the limit register is the bound
  assign bound    = have_best_q ? best_dist_q : njvs_pkg::SUM_W'(limit_i);
  assign take     = entry_i.sum < bound;
  assign out_free = !res_valid_q || res_o.ready;
  assign pop_o    = valid_i && (!entry_i.last || out_free);
  assign emit     = pop_o && entry_i.last;

  assign found   = take || have_best_q;
  assign win_pos = take ? count_q : best_pos_q;
  assign win_ang = take ? entry_i.angles : best_ang_q;

  always_comb begin
    res_d.found        = found;
    res_d.best_index   = found ? njvs_pkg::index_t'(win_pos) : '0;
    res_d.best_joint_0 = found ? win_ang[0] : '0;
    res_d.best_joint_1 = found ? win_ang[1] : '0;
    res_d.best_joint_2 = found ? win_ang[2] : '0;
    res_d.best_joint_3 = found ? win_ang[3] : '0;
    res_d.best_joint_4 = found ? win_ang[4] : '0;
    res_d.best_joint_5 = found ? win_ang[5] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      have_best_q <= 1'b0;
      count_q     <= '0;
    end else begin
      if (emit) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      if (pop_o) begin
        if (entry_i.last) begin
          have_best_q <= 1'b0;
          count_q     <= '0;
        end else begin
          if (take) begin
            have_best_q <= 1'b1;
          end
          count_q <= (count_q == njvs_pkg::CNT_W'(njvs_pkg::MAX_CANDIDATES - 1))
                   ? '0 : count_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_data_q <= res_d;
    end
    if (pop_o && take) begin
      best_dist_q <= entry_i.sum;
      best_pos_q  <= count_q;
      best_ang_q  <= entry_i.angles;
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_data_q;

  `NJVS_ASSERT(a_res_from_last, clk_i, rst_ni, $rose(res_valid_q) |-> $past(emit))
  `NJVS_ASSERT(a_set_cleared, clk_i, rst_ni, emit |=> (!have_best_q && (count_q == '0)))

endmodule
`default_nettype wire

### design/nearest_joint_vector_select.sv
// nearest joint vector select: picks the candidate joint vector with the
// smallest l1 distance to a programmable reference vector.
// channels: cand_i takes one request per candidate (six signed q3.12 angles
// and a last mark); res_o gives one result per set, on its last request;
// cfg_i writes the six reference angles (index 0..5) and the distance limit
// (index 6); the user must write only while the block is idle (not enforced).
// path: a last request passes the front stage, queue and result registers.
// throughput: one request per cycle unless a stalled result holds the flow;
// the front end registers the six absolute differences, the adder tree feeds a
// two entry queue, and the back end does one compare and update per cycle.
// a stalled result holds in the output register; the queue and the front
// stage keep taking requests until both are full, then cand_i.ready drops.
// reset: references clear to 0, the limit returns to 100 rad, the set is
// empty and no result is pending.
// depends on njvs_pkg, njvs_if, njvs_front, njvs_queue and njvs_back
`timescale 1ns / 1ps
`default_nettype none
module nearest_joint_vector_select (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  njvs_cfg_if.sink      cfg_i,
  njvs_cand_if.sink     cand_i,
  njvs_result_if.source res_o
);

  // configuration registers
  njvs_pkg::angle_vec_t ref_joint_q;
  njvs_pkg::limit_t     limit_q;

  // front to queue
  logic                 push;
  logic                 q_ready;
  njvs_pkg::entry_t     front_entry;

  // queue to back
  logic                 q_valid;
  logic                 pop;
  njvs_pkg::entry_t     head_entry;

  // register writes are always accepted
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_joint_q <= '0;
      limit_q     <= njvs_pkg::DEFAULT_LIMIT;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        njvs_pkg::CFG_REF_JOINT_0: begin
          ref_joint_q[0] <= cfg_i.data.wdata[njvs_pkg::ANGLE_W-1:0];
        end
        njvs_pkg::CFG_REF_JOINT_1: begin
          ref_joint_q[1] <= cfg_i.data.wdata[njvs_pkg::ANGLE_W-1:0];
        end
        njvs_pkg::CFG_REF_JOINT_2: begin
          ref_joint_q[2] <= cfg_i.data.wdata[njvs_pkg::ANGLE_W-1:0];
        end
        njvs_pkg::CFG_REF_JOINT_3: begin
          ref_joint_q[3] <= cfg_i.data.wdata[njvs_pkg::ANGLE_W-1:0];
        end
        njvs_pkg::CFG_REF_JOINT_4: begin
          ref_joint_q[4] <= cfg_i.data.wdata[njvs_pkg::ANGLE_W-1:0];
        end
        njvs_pkg::CFG_REF_JOINT_5: begin
          ref_joint_q[5] <= cfg_i.data.wdata[njvs_pkg::ANGLE_W-1:0];
        end
        njvs_pkg::CFG_DISTANCE_LIMIT: begin
          limit_q <= cfg_i.data.wdata;
        end
        default: begin
          // writes past the register list are dropped
        end
      endcase
    end
  end

  // distance per candidate
  njvs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cand_i      (cand_i),
    .ref_joint_i (ref_joint_q),
    .q_ready_i   (q_ready),
    .push_o      (push),
    .entry_o     (front_entry)
  );

  // decouples distance calculation from selection
  njvs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .pop_i   (pop),
    .entry_o (head_entry)
  );

  // running best and result register
  njvs_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .entry_i (head_entry),
    .pop_o   (pop),
    .limit_i (limit_q),
    .res_o   (res_o)
  );

endmodule
`default_nettype wire
